@@ hdl/dmpq_pkg.sv @@
// Package: types and constants for the d-ary min priority queue.
package dmpq_pkg;
    localparam int CAPACITY  = 128;
    localparam int MAX_ARITY = 8;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REDUCE = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_GREATER   = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic [6:0]         slot;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] removed_key;
        logic signed [31:0] removed_value;
        logic               top_valid;
        logic signed [31:0] top_key;
        logic signed [31:0] top_value;
        logic [7:0]         count;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_entry;
endpackage

@@ hdl/dmpq_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
module dmpq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/dary_min_priority_queue.sv @@
// Top level: d-ary min heap sequencer over one synchronous heap RAM.
//  channel | signals                     | dir
//  cmd     | i_valid / o_ready / i_word  | in
//  result  | o_valid / i_ready / o_word  | out
//  config  | i_cfg_we / i_cfg_data       | in
// One word at a time. Each sift-up level reads the parent, then compares and
// writes; each sift-down level reads the children, one child read a cycle, drains
// the last read, then compares and writes. The root is cached in registers for
// the top fields. Reset clears count and control and loads arity 5; no other
// register is reset. Input is refused while a word is in work or the result
// register is full and not taken.
module dary_min_priority_queue
    import dmpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word,
    input  logic      i_cfg_we,
    input  logic [3:0] i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD_SLOT, S_CHK_SLOT, S_UP_RD, S_UP_CMP, S_DEL_RD, S_DEL_LAST,
        S_DN_RD, S_DN_CMP, S_DONE
    } t_state;

    t_state        r_state;
    logic [3:0]    r_arity;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_i;       // position of moving entry
    t_entry        r_cur;     // moving entry
    logic [AW-1:0] r_p;       // parent or child address
    logic [3:0]    r_k;       // child index
    logic          r_found;
    logic [AW-1:0] r_best;
    t_entry        r_bestv;
    logic          r_pend;    // read of child pending
    t_entry        r_root;
    logic [2:0]    r_status;
    t_entry        r_rem;
    logic          r_ovalid;
    t_in_word      r_in;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic [3:0]    ar;
    logic [AW+4:0] base;
    logic [AW+4:0] cidx;

    dmpq_ram #(.DEPTH(CAPACITY), .WIDTH(64)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        ar = r_arity;
        if (ar < 4'd2) ar = 4'd2;
        if (ar > 4'(MAX_ARITY)) ar = 4'(MAX_ARITY);
    end

    assign base = (AW+5)'(r_i) * (AW+5)'(ar);
    assign cidx = base + (AW+5)'(r_k);
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;

    // parent of r_i: (r_i-1)/arity as a reciprocal multiply, exact for 7-bit positions
    logic [AW-1:0] par;
    logic [AW-1:0] im1;
    logic [AW+9:0] pprod;
    always_comb begin
        im1 = r_i - AW'(1);
        case (ar)
            4'd2:    pprod = (AW+10)'(im1) * (AW+10)'(512);
            4'd3:    pprod = (AW+10)'(im1) * (AW+10)'(342);
            4'd4:    pprod = (AW+10)'(im1) * (AW+10)'(256);
            4'd5:    pprod = (AW+10)'(im1) * (AW+10)'(205);
            4'd6:    pprod = (AW+10)'(im1) * (AW+10)'(171);
            4'd7:    pprod = (AW+10)'(im1) * (AW+10)'(147);
            4'd8:    pprod = (AW+10)'(im1) * (AW+10)'(128);
            default: pprod = '0;
        endcase
        par = pprod[AW+9:10];
    end

    // RAM read port driven by state
    always_comb begin
        raddr = r_p;
        case (r_state)
            S_IDLE:   raddr = i_word.slot;
            S_UP_RD:  raddr = par;
            S_DEL_RD: raddr = AW'(r_count);
            S_DN_RD:  raddr = AW'(cidx);
            default:  raddr = r_p;
        endcase
    end

    t_entry wr_e; logic [AW-1:0] wr_a; logic wr_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_arity  <= 4'd5;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) r_arity <= i_cfg_data;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_in <= i_word; r_status <= ST_OK; r_rem <= '0;
                    case (i_word.cmd)
                        CMD_INSERT: if (r_count >= CW'(CAPACITY)) begin
                            r_status <= ST_OVERFLOW; r_state <= S_DONE;
                        end else begin
                            r_i <= AW'(r_count);
                            r_cur <= '{i_word.key, i_word.value};
                            r_count <= r_count + CW'(1);
                            r_state <= S_UP_RD;
                        end
                        CMD_REDUCE: if (CW'(i_word.slot) >= r_count) begin
                            r_status <= ST_BAD_SLOT; r_state <= S_DONE;
                        end else begin
                            r_i <= AW'(i_word.slot); r_state <= S_CHK_SLOT;
                        end
                        CMD_DELETE: if (r_count == '0) begin
                            r_status <= ST_UNDERFLOW;
                            r_rem <= '{INT_MAX, 32'sd0}; r_state <= S_DONE;
                        end else begin
                            r_rem <= r_root; r_count <= r_count - CW'(1);
                            r_state <= S_DEL_RD;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_CHK_SLOT: begin
                    if (r_in.key > rdata.key) begin
                        r_status <= ST_GREATER; r_state <= S_DONE;
                    end else begin
                        r_cur <= '{r_in.key, rdata.value}; r_state <= S_UP_RD;
                    end
                end
                S_UP_RD: begin
                    if (r_i == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_p <= par; r_state <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if (r_cur.key < rdata.key) begin
                        r_i <= r_p;
                        r_state <= S_UP_RD;
                    end else r_state <= S_DONE;
                end
                S_DEL_RD: r_state <= S_DEL_LAST;
                S_DEL_LAST: begin
                    r_cur <= rdata; r_i <= '0; r_k <= 4'd1;
                    r_found <= 1'b0; r_pend <= 1'b0;
                    r_state <= (r_count == '0) ? S_DONE : S_DN_RD;
                end
                S_DN_RD: begin
                    // issue child read; evaluate previous one
                    if (r_pend && (!r_found || rdata.key < r_bestv.key)) begin
                        r_found <= 1'b1; r_best <= r_p; r_bestv <= rdata;
                    end
                    if (r_k <= ar && cidx < (AW+5)'(r_count)) begin
                        r_p <= AW'(cidx); r_pend <= 1'b1; r_k <= r_k + 4'd1;
                    end else begin
                        r_pend <= 1'b0; r_state <= S_DN_CMP;
                    end
                end
                S_DN_CMP: begin
                    if (r_found && r_cur.key > r_bestv.key) begin
                        r_i <= r_best; r_k <= 4'd1; r_found <= 1'b0;
                        r_state <= S_DN_RD;
                    end else r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // write-back: parent slides down on sift-up swap, child slides up on sift-down,
    // and the moving entry lands when its walk ends
    always_comb begin
        wr_en = 1'b0; wr_a = r_i; wr_e = r_cur;
        case (r_state)
            S_UP_CMP: if (r_cur.key < rdata.key) begin
                wr_en = 1'b1; wr_a = r_i; wr_e = rdata;
            end else wr_en = 1'b1;
            S_UP_RD: wr_en = (r_i == '0);
            S_DN_CMP: if (r_found && r_cur.key > r_bestv.key) begin
                wr_en = 1'b1; wr_a = r_i; wr_e = r_bestv;
            end else wr_en = 1'b1;
            S_DEL_LAST: wr_en = (r_count == '0);
            default: wr_en = 1'b0;
        endcase
    end
    // S_DEL_LAST with empty heap raises wr_en, but we is masked there, so nothing is written
    assign we = wr_en && !(r_state == S_DEL_LAST);
    assign waddr = wr_a;
    assign wdata = wr_e;

    // root cache follows every write to slot 0
    always_ff @(posedge i_clk) begin
        if (we && wr_a == '0) r_root <= wr_e;
    end

    always_comb begin
        o_word.status        = r_status;
        o_word.removed_key   = r_rem.key;
        o_word.removed_value = r_rem.value;
        o_word.top_valid     = (r_count != '0);
        o_word.top_key       = (r_count != '0) ? r_root.key : 32'sd0;
        o_word.top_value     = (r_count != '0) ? r_root.value : 32'sd0;
        o_word.count         = 8'(r_count);
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count overrun");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("result lost");
endmodule

@@ tb/tb_top.sv @@
// Testbench for the d-ary min priority queue: directed table, random traffic, heap predictor.
module tb_top;
    import dmpq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS = 600;
    localparam longint CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_word;
    logic      i_cfg_we;
    logic [3:0] i_cfg_data;

    dary_min_priority_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(i_word),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [31:0] heap_key [CAPACITY];
    logic signed [31:0] heap_val [CAPACITY];
    int unsigned        heap_len;
    logic [3:0]         arity_reg;

    t_out_word   pending_q[$];
    int          mismatches;
    bit          hold_long;
    bit          stim_done;
    longint      cycles;

    typedef struct {
        t_in_word  word;
        bit        has_exp;
        t_out_word exp_word;
    } t_row;
    t_row rows[$];

    function automatic int unsigned arity_now();
        int unsigned r;
        r = arity_reg;
        if (r < 2) r = 2;
        if (r > MAX_ARITY) r = MAX_ARITY;
        return r;
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic signed [31:0] tk, tv;
        tk = heap_key[a]; tv = heap_val[a];
        heap_key[a] = heap_key[b]; heap_val[a] = heap_val[b];
        heap_key[b] = tk; heap_val[b] = tv;
    endfunction

    function automatic void bubble_up(int unsigned i);
        int unsigned r, p;
        r = arity_now();
        while (i > 0) begin
            p = (i - 1) / r;
            if (!(heap_key[i] < heap_key[p])) break;
            swap_entries(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int unsigned i);
        int unsigned r, c, best;
        bit found;
        r = arity_now();
        while (i < heap_len) begin
            found = 0;
            best = 0;
            for (int unsigned k = 1; k <= r; k++) begin
                c = r * i + k;
                if (c < heap_len && (!found || heap_key[c] < heap_key[best])) begin
                    best = c;
                    found = 1;
                end
            end
            if (!found || !(heap_key[i] > heap_key[best])) break;
            swap_entries(i, best);
            i = best;
        end
    endfunction

    function automatic t_out_word heap_apply(t_in_word w);
        t_out_word o;
        o = '0;
        o.status = ST_OK;
        case (w.cmd)
            CMD_INSERT: begin
                if (heap_len >= CAPACITY) begin
                    o.status = ST_OVERFLOW;
                end else begin
                    heap_key[heap_len] = w.key;
                    heap_val[heap_len] = w.value;
                    heap_len++;
                    bubble_up(heap_len - 1);
                end
            end
            CMD_REDUCE: begin
                if (w.slot >= heap_len) begin
                    o.status = ST_BAD_SLOT;
                end else if (w.key > heap_key[w.slot]) begin
                    o.status = ST_GREATER;
                end else begin
                    heap_key[w.slot] = w.key;
                    bubble_up(w.slot);
                end
            end
            CMD_DELETE: begin
                if (heap_len == 0) begin
                    o.status = ST_UNDERFLOW;
                    o.removed_key = INT_MAX;
                end else begin
                    o.removed_key = heap_key[0];
                    o.removed_value = heap_val[0];
                    heap_len--;
                    heap_key[0] = heap_key[heap_len];
                    heap_val[0] = heap_val[heap_len];
                    bubble_down(0);
                end
            end
            default: ;
        endcase
        if (heap_len > 0) begin
            o.top_valid = 1'b1;
            o.top_key = heap_key[0];
            o.top_value = heap_val[0];
        end
        o.count = heap_len[7:0];
        return o;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 99) < 5) return $urandom_range(10, 40);
        if ($urandom_range(0, 99) < 50) return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic t_in_word make_word(logic [1:0] c, logic signed [31:0] k,
                                          logic signed [31:0] v, logic [6:0] s);
        t_in_word w;
        w.cmd = c; w.key = k; w.value = v; w.slot = s;
        return w;
    endfunction

    function automatic t_out_word make_result(logic [2:0] st, logic signed [31:0] rk,
                                              logic signed [31:0] rv, logic tv,
                                              logic signed [31:0] tk,
                                              logic signed [31:0] tvl, logic [7:0] n);
        t_out_word o;
        o.status = st; o.removed_key = rk; o.removed_value = rv;
        o.top_valid = tv; o.top_key = tk; o.top_value = tvl; o.count = n;
        return o;
    endfunction

    function automatic void add_row(t_in_word w, bit has, t_out_word e);
        t_row r;
        r.word = w; r.has_exp = has; r.exp_word = e;
        rows.push_back(r);
    endfunction

    // random word with content biased toward ties and extremes
    function automatic t_in_word random_word();
        t_in_word w;
        int sel;
        w.value = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 2) w.key = $urandom_range(0, 7) - 4;
        else if (sel == 2) w.key = ($urandom_range(0, 1) != 0) ? INT_MAX : -INT_MAX - 1;
        else w.key = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 45) w.cmd = CMD_INSERT;
        else if (sel < 65) w.cmd = CMD_REDUCE;
        else if (sel < 97) w.cmd = CMD_DELETE;
        else w.cmd = 2'd3;
        if (w.cmd == CMD_REDUCE && heap_len > 0 && $urandom_range(0, 9) < 8) begin
            w.slot = 7'($urandom_range(0, heap_len - 1));
            if ($urandom_range(0, 3) != 0)
                w.key = heap_key[w.slot] - $urandom_range(0, 1000);
        end else begin
            w.slot = 7'($urandom);
        end
        return w;
    endfunction

    // valid stays high across a zero gap; the next word replaces the payload
    task automatic send_word(t_in_word w);
        int gap;
        gap = short_or_long_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        pending_q.push_back(heap_apply(w));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_queue();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_arity(logic [3:0] a);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a;
        arity_reg = a;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_long = 0;
            end
            gap = short_or_long_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", o_word);
            end else begin
                e = pending_q.pop_front();
                if (o_word !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, o_word);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[dary_min_priority_queue] ERROR");
            $finish;
        end
    end

    initial begin
        logic [3:0] arities[$];
        int n;
        i_rst_n = 1'b0; i_valid = 1'b0; i_word = '0;
        i_cfg_we = 1'b0; i_cfg_data = 4'd0;
        mismatches = 0; hold_long = 0; stim_done = 0; cycles = 0;
        heap_len = 0; arity_reg = 4'd5;
        for (int i = 0; i < CAPACITY; i++) begin
            heap_key[i] = '0; heap_val[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; error codes, empty-heap rows and the two extreme-key inserts typed in
        add_row(make_word(CMD_DELETE, 0, 0, 0), 1,
                make_result(ST_UNDERFLOW, INT_MAX, 0, 0, 0, 0, 0));
        add_row(make_word(CMD_REDUCE, -5, 0, 0), 1,
                make_result(ST_BAD_SLOT, 0, 0, 0, 0, 0, 0));
        add_row(make_word(2'd3, 0, 0, 7'h7f), 1, make_result(ST_OK, 0, 0, 0, 0, 0, 0));
        add_row(make_word(CMD_INSERT, INT_MAX, -1, 7'h7f), 1,
                make_result(ST_OK, 0, 0, 1, INT_MAX, -1, 1));
        add_row(make_word(CMD_INSERT, -INT_MAX - 1, INT_MAX, 0), 1,
                make_result(ST_OK, 0, 0, 1, -INT_MAX - 1, INT_MAX, 2));
        add_row(make_word(CMD_INSERT, 10, 32'sh5555aaaa, 0), 0, '0);
        add_row(make_word(CMD_INSERT, 10, 32'shaaaa5555, 0), 0, '0);
        add_row(make_word(CMD_INSERT, 3, 7, 0), 0, '0);
        add_row(make_word(CMD_REDUCE, 100, 0, 2), 0, '0);
        add_row(make_word(CMD_REDUCE, 10, 0, 2), 0, '0);
        add_row(make_word(CMD_REDUCE, -INT_MAX - 1, 0, 3), 0, '0);
        add_row(make_word(CMD_REDUCE, 0, 0, 7'h7f), 0, '0);
        add_row(make_word(2'd3, -1, -1, 7'h55), 0, '0);
        for (int i = 0; i < 7; i++) add_row(make_word(CMD_DELETE, 0, 0, 0), 0, '0);
        foreach (rows[i]) begin
            t_out_word exp_w;
            send_word(rows[i].word);
            exp_w = pending_q[pending_q.size() - 1];
            if (rows[i].has_exp && exp_w !== rows[i].exp_word) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: expected %p predicted %p",
                             i, rows[i].exp_word, exp_w);
            end
        end
        drain_queue();

        // fill to overflow with receiver held off, arity 2
        write_arity(4'd2);
        hold_long = 1;
        for (int i = 0; i < CAPACITY + 3; i++)
            send_word(make_word(CMD_INSERT, $urandom_range(0, 20) - 10, $urandom, 0));
        drain_queue();
        for (int i = 0; i < CAPACITY + 2; i++)
            send_word(make_word(CMD_DELETE, $urandom, $urandom, 7'($urandom)));
        drain_queue();

        // random phases across arity settings, extremes and clamped values included
        arities = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5, 4'd9};
        n = 0;
        foreach (arities[a]) begin
            write_arity(arities[a]);
            for (int i = 0; i < 50; i++) begin
                send_word(random_word());
                n++;
            end
            drain_queue();
        end
        stim_done = 1;

        drain_queue();
        if (mismatches == 0) begin
            $display("[dary_min_priority_queue] OK");
        end else begin
            $display("[dary_min_priority_queue] ERROR");
        end
        $finish;
    end
endmodule
